>>> hdl/ngst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngst_pkg
// shared constants and controller/datapath command types
// ----------------------------------------------------------------------------
package ngst_pkg;
  localparam int LEAF_COUNT_DEFAULT = 1024;
  localparam int POS_W              = 10;
  localparam int CNT_W              = 11;
  localparam int HEIGHT_W           = 32;
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 32'sh8000_0000;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic clr_step;   // capture left child value into compare register
    logic clear_wr;   // write the minimum at the clearing address
    logic wr_leaf;    // write leaf
    logic wr_node;    // write parent with max of captured children
    logic rd_left;    // read left child of node
    logic rd_right;   // read right child of node
    logic take_h;     // capture queried height
    logic rd_scan_l;  // read next left leaf
    logic rd_scan_r;  // read next right leaf
    logic scan_l;     // compare one left leaf
    logic scan_r;     // compare one right leaf
  } ngst_cmd_t;

  typedef struct packed {
    logic clear_done; // clearing pass at last entry
    logic root_done;  // climb has written the root
    logic left_done;  // left scan finished
    logic right_done; // right scan finished
    logic in_range;   // position below live count
    logic is_write;
  } ngst_sts_t;
endpackage

>>> hdl/ngst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngst_in_if / ngst_out_if
// valid/ready channels for items and results
// ----------------------------------------------------------------------------
interface ngst_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic [ngst_pkg::POS_W-1:0]             position;
  logic signed [ngst_pkg::HEIGHT_W-1:0]   new_height;
  modport source (output valid, opcode, position, new_height, input ready);
  modport sink   (input valid, opcode, position, new_height, output ready);
endinterface

interface ngst_out_if;
  logic                       valid;
  logic                       ready;
  logic [ngst_pkg::POS_W-1:0] left_limit;
  logic [ngst_pkg::POS_W-1:0] right_limit;
  modport source (output valid, left_limit, right_limit, input ready);
  modport sink   (input valid, left_limit, right_limit, output ready);
endinterface

>>> hdl/ngst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngst_datapath
// tree memory, address pointer, compare and scan registers
// ----------------------------------------------------------------------------
module ngst_datapath #(
  parameter int LEAF_COUNT = ngst_pkg::LEAF_COUNT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ngst_pkg::ngst_cmd_t                  cmd,
  output ngst_pkg::ngst_sts_t                  sts,
  input  logic [ngst_pkg::CNT_W-1:0]           element_count,
  input  logic                                 in_opcode,
  input  logic [ngst_pkg::POS_W-1:0]           in_position,
  input  logic signed [ngst_pkg::HEIGHT_W-1:0] in_height,
  output logic [ngst_pkg::POS_W-1:0]           left_limit,
  output logic [ngst_pkg::POS_W-1:0]           right_limit
);
  localparam int AW = $clog2(2 * LEAF_COUNT);
  localparam int LW = $clog2(LEAF_COUNT);
  localparam int IW = (LW > ngst_pkg::CNT_W) ? LW + 1 : ngst_pkg::CNT_W + 1;

  logic signed [ngst_pkg::HEIGHT_W-1:0] mem [2*LEAF_COUNT];
  logic signed [ngst_pkg::HEIGHT_W-1:0] rdata, a_val, h;
  logic [AW-1:0] node, raddr;
  logic [IW-1:0] live, li, ri;
  logic op, lfound, rfound;
  logic [IW-1:0] leaf_ext;
  logic [AW-1:0] waddr;
  logic [AW-1:0] clear_addr;
  logic signed [ngst_pkg::HEIGHT_W-1:0] wdata;
  logic signed [ngst_pkg::HEIGHT_W-1:0] rval;

  // live count saturates at the leaf count
  always_comb begin
    if (IW'(element_count) > IW'(LEAF_COUNT)) live = IW'(LEAF_COUNT);
    else live = IW'(element_count);
  end

  assign leaf_ext = IW'(in_position);
  assign rval     = rdata;

  always_comb begin
    raddr = node;
    if (cmd.rd_left)   raddr = {node[AW-2:0], 1'b0};
    if (cmd.rd_right)  raddr = {node[AW-2:0], 1'b1};
    if (cmd.rd_scan_l) raddr = AW'(LEAF_COUNT) + AW'(li - IW'(1));
    if (cmd.rd_scan_r) raddr = AW'(LEAF_COUNT) + AW'(ri);
    waddr = cmd.clear_wr ? clear_addr : node;
    wdata = (a_val > rval) ? a_val : rval;
    if (cmd.wr_leaf) wdata = h;
    if (cmd.clear_wr) wdata = ngst_pkg::HEIGHT_MIN;
  end

  // registered-read tree memory
  always_ff @(posedge clk) begin
    if (cmd.wr_leaf || cmd.wr_node || cmd.clear_wr) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // clearing pass address, one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) clear_addr <= '0;
    else if (cmd.clear_wr) clear_addr <= clear_addr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= in_opcode;
      node   <= AW'(LEAF_COUNT) + AW'(in_position);
      h      <= in_height;
      li     <= leaf_ext;
      ri     <= leaf_ext + IW'(1);
      lfound <= 1'b0;
      rfound <= 1'b0;
    end
    if (cmd.wr_leaf || cmd.wr_node) node <= {1'b0, node[AW-1:1]};
    if (cmd.rd_left) a_val <= a_val;
    if (cmd.take_h) a_val <= rval;
    if (cmd.clr_step) a_val <= rval;
    if (cmd.take_h) h <= rval;
    if (cmd.scan_l && !lfound && li != '0) begin
      if (rval > h) lfound <= 1'b1;
      else li <= li - IW'(1);
    end
    if (cmd.scan_r && !rfound && ri < live) begin
      if (rval > h) rfound <= 1'b1;
      else ri <= ri + IW'(1);
    end
  end

  assign sts.clear_done = (clear_addr == AW'(2 * LEAF_COUNT - 1));
  assign sts.root_done  = (node == '0);
  assign sts.left_done  = lfound || li == '0;
  assign sts.right_done = rfound || ri >= live;
  assign sts.in_range   = leaf_ext < live;
  assign sts.is_write   = op;
  assign left_limit  = lfound ? ngst_pkg::POS_W'(li - IW'(1)) : '0;
  assign right_limit = rfound ? ngst_pkg::POS_W'(ri) : ngst_pkg::POS_W'(live - IW'(1));
endmodule

>>> hdl/ngst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngst_ctrl
// sequencer for write climb and query scans
// ----------------------------------------------------------------------------
module ngst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_range,
  output logic                out_valid,
  input  logic                out_ready,
  output ngst_pkg::ngst_cmd_t cmd,
  input  ngst_pkg::ngst_sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RL = 4'd2, S_RR = 4'd3,
                         S_CLR = 4'd4, S_WN = 4'd5, S_QH = 4'd6, S_QW = 4'd7,
                         S_LR = 4'd8, S_LC = 4'd9, S_RRD = 4'd10, S_RC = 4'd11,
                         S_OUT = 4'd12;
  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_range) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_write) begin
          cmd.wr_leaf = 1'b1;
          state_next = S_RL;
        end else begin
          state_next = S_QH;
        end
      end
      S_RL: begin
        if (sts.root_done) state_next = S_IDLE;
        else begin
          cmd.rd_left = 1'b1;
          state_next = S_RR;
        end
      end
      S_RR: begin
        cmd.rd_right = 1'b1;
        cmd.clr_step = 1'b1;
        state_next = S_WN;
      end
      S_WN: begin
        cmd.wr_node = 1'b1;
        state_next = S_RL;
      end
      S_QH: state_next = S_QW;
      S_QW: begin
        cmd.take_h = 1'b1;
        state_next = S_LR;
      end
      S_LR: begin
        if (sts.left_done) state_next = S_RRD;
        else begin
          cmd.rd_scan_l = 1'b1;
          state_next = S_LC;
        end
      end
      S_LC: begin
        cmd.scan_l = 1'b1;
        state_next = S_LR;
      end
      S_RRD: begin
        if (sts.right_done) state_next = S_OUT;
        else begin
          cmd.rd_scan_r = 1'b1;
          state_next = S_RC;
        end
      end
      S_RC: begin
        cmd.scan_r = 1'b1;
        state_next = S_RRD;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.load) else $error("load while busy");
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_WN) |=> !out_valid) else $error("write made result");
`endif
endmodule

>>> hdl/nearest_greater_segment_tree_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_greater_segment_tree_unit
// max segment tree with nearest strictly greater neighbor queries
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass writes the most negative
// height into all 2*LEAF_COUNT tree entries, one per cycle, and no item is
// taken until it ends. A write stores the leaf and then climbs to the root,
// with two child reads and a parent write per level on the single tree
// memory. A query reads its leaf and scans leaves outward on each side, left
// first and then right, until a strictly greater height or the row end.
// Out-of-range items are taken with no effect. The result waits in the
// output stage until transferred.
module nearest_greater_segment_tree_unit #(
  parameter int LEAF_COUNT = ngst_pkg::LEAF_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  ngst_in_if.sink                       item,
  ngst_out_if.source                    result,
  input  logic                          cfg_we,
  input  logic [ngst_pkg::CNT_W-1:0]    cfg_wdata
);
  ngst_pkg::ngst_cmd_t cmd;
  ngst_pkg::ngst_sts_t sts;
  logic [ngst_pkg::CNT_W-1:0] element_count;
  logic busy_ready;

  // element count register
  always_ff @(posedge clk) begin
    if (rst) element_count <= ngst_pkg::COUNT_RESET;
    else if (cfg_we) element_count <= cfg_wdata;
  end

  assign item.ready = busy_ready;

  ngst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(item.valid), .in_ready(busy_ready),
    .in_range(sts.in_range), .out_valid(result.valid), .out_ready(result.ready),
    .cmd(cmd), .sts(sts)
  );

  ngst_datapath #(.LEAF_COUNT(LEAF_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .element_count(element_count),
    .in_opcode(item.opcode), .in_position(item.position),
    .in_height(item.new_height),
    .left_limit(result.left_limit), .right_limit(result.right_limit)
  );
endmodule
